// ===== rtl/core/cmpt_pkg.sv =====
`timescale 1ns / 1ps

package cmpt_pkg;

    // Field widths
    localparam int WORD_W        = 64;
    localparam int TGT_W         = 256;
    localparam int BYTE_W        = 8;
    localparam int TGT_BYTES     = TGT_W / BYTE_W;
    localparam int LEAD_W        = $clog2(TGT_BYTES);
    localparam int COMPACT_W     = 32;
    localparam int COMPACT_OUT_W = 30;
    localparam int MANT_W        = 24;
    localparam int EXP_W         = 8;
    localparam int EXP_OUT_W     = COMPACT_OUT_W - MANT_W;

    // Exponent limits for expansion
    localparam logic [EXP_W-1:0] EXP_MANT_BYTES = 8'd3;
    localparam logic [EXP_W-1:0] EXP_SAT        = 8'd33;

    // Exponent of a target whose first byte is nonzero
    localparam logic [EXP_OUT_W-1:0] EXP_TOP = 6'd32;

    // Operation select
    localparam logic FUNC_EXPAND   = 1'b0;
    localparam logic FUNC_COMPRESS = 1'b1;

    typedef struct packed {
        logic                 func;
        logic [COMPACT_W-1:0] compact;
        logic [TGT_W-1:0]     tgt;
    } conv_req_t;

    typedef struct packed {
        logic [TGT_W-1:0]         tgt;
        logic [COMPACT_OUT_W-1:0] compact;
    } conv_rsp_t;

endpackage

// ===== rtl/core/cmpt_req_if.sv =====
`timescale 1ns / 1ps

interface cmpt_req_if
    import cmpt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [COMPACT_W-1:0] compact_in;
    logic [WORD_W-1:0]    tgt_in_3;
    logic [WORD_W-1:0]    tgt_in_2;
    logic [WORD_W-1:0]    tgt_in_1;
    logic [WORD_W-1:0]    tgt_in_0;

    modport source
    (
        output valid, func, compact_in, tgt_in_3, tgt_in_2, tgt_in_1, tgt_in_0,
        input  ready
    );

    modport sink
    (
        input  valid, func, compact_in, tgt_in_3, tgt_in_2, tgt_in_1, tgt_in_0,
        output ready
    );
endinterface

// ===== rtl/core/cmpt_rsp_if.sv =====
`timescale 1ns / 1ps

interface cmpt_rsp_if
    import cmpt_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [WORD_W-1:0]        tgt_out_3;
    logic [WORD_W-1:0]        tgt_out_2;
    logic [WORD_W-1:0]        tgt_out_1;
    logic [WORD_W-1:0]        tgt_out_0;
    logic [COMPACT_OUT_W-1:0] compact_out;

    modport source
    (
        output valid, tgt_out_3, tgt_out_2, tgt_out_1, tgt_out_0, compact_out,
        input  ready
    );

    modport sink
    (
        input  valid, tgt_out_3, tgt_out_2, tgt_out_1, tgt_out_0, compact_out,
        output ready
    );
endinterface

// ===== rtl/core/cmpt_expand.sv =====
`timescale 1ns / 1ps

module cmpt_expand
    import cmpt_pkg::*;
(
    input  logic [COMPACT_W-1:0] compact,
    output logic [TGT_W-1:0]     tgt
);

    logic [EXP_W-1:0]  exp_val;
    logic [MANT_W-1:0] mant;
    logic [TGT_W-1:0]  wide;
    logic [1:0]        rsh_bytes;
    logic [4:0]        lsh_bytes;
    logic [EXP_W-1:0]  exp_less;

    assign exp_val   = compact[COMPACT_W-1 -: EXP_W];
    assign mant      = compact[MANT_W-1:0];
    assign wide      = {{(TGT_W - MANT_W){1'b0}}, mant};
    // exponent 0..3: right shift by 3 - exponent bytes
    assign rsh_bytes = ~exp_val[1:0];
    assign exp_less  = exp_val - EXP_MANT_BYTES;
    assign lsh_bytes = exp_less[4:0];

    always_comb
    begin
        if ((compact == '0) || (exp_val >= EXP_SAT))
        begin
            tgt = '1;
        end
        else if (exp_val <= EXP_MANT_BYTES)
        begin
            tgt = wide >> {rsh_bytes, 3'b000};
        end
        else
        begin
            tgt = wide << {lsh_bytes, 3'b000};
        end
    end

endmodule

// ===== rtl/core/cmpt_compress.sv =====
`timescale 1ns / 1ps

module cmpt_compress
    import cmpt_pkg::*;
(
    input  logic [TGT_W-1:0]         tgt,
    output logic [COMPACT_OUT_W-1:0] compact
);

    logic [LEAD_W-1:0]    lead;
    logic                 found;
    logic [TGT_W-1:0]     aligned;
    logic [MANT_W-1:0]    mant_raw;
    logic [EXP_OUT_W-1:0] exp_raw;
    logic [MANT_W-1:0]    mant;
    logic [EXP_OUT_W-1:0] exp_val;

    // leading nonzero byte, byte 0 being the most significant
    always_comb
    begin
        lead  = '0;
        found = 1'b0;
        for (int k = TGT_BYTES - 1; k >= 0; k--)
        begin
            if (tgt[TGT_W - 1 - BYTE_W * k -: BYTE_W] != '0)
            begin
                lead  = LEAD_W'(k);
                found = 1'b1;
            end
        end
    end

    // bytes beyond the end shift in as zero
    assign aligned  = tgt << {lead, 3'b000};
    assign mant_raw = aligned[TGT_W-1 -: MANT_W];
    assign exp_raw  = EXP_TOP - {1'b0, lead};

    always_comb
    begin
        if (mant_raw[MANT_W-1])
        begin
            mant    = {{BYTE_W{1'b0}}, mant_raw[MANT_W-1:BYTE_W]};
            exp_val = exp_raw + 6'd1;
        end
        else
        begin
            mant    = mant_raw;
            exp_val = exp_raw;
        end
    end

    assign compact = found ? {exp_val, mant} : '0;

endmodule

// ===== rtl/core/compact_target_converter.sv =====
`timescale 1ns / 1ps

// Channel   Modport        Item
// --------  -------------  -------------------------------------------------
// conv_req  cmpt_req_if    func, compact_in, tgt_in_3..tgt_in_0
// conv_rsp  cmpt_rsp_if    tgt_out_3..tgt_out_0, compact_out
//
// One item a cycle while conv_rsp is not stalled: an input register
// feeds the expand and compress logic, whose result lands in the output register.
// Reset clears only the two valid flags; payload registers are not reset.
// A stalled result holds in the output register while the input register still
// takes a fresh item, so ready drops only when both stages are full.

module compact_target_converter
    import cmpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cmpt_req_if.sink    conv_req,
    cmpt_rsp_if.source  conv_rsp
);

    // Stage 1: registered request
    logic      s1_valid_reg;
    logic      s1_valid_next;
    conv_req_t s1_item_reg;
    conv_req_t req_item;

    // Stage 2: registered result
    logic      out_valid_reg;
    logic      out_valid_next;
    conv_rsp_t out_item_reg;
    conv_rsp_t out_item_next;

    logic out_adv;
    logic s1_ready;
    logic req_take;

    logic [TGT_W-1:0]         exp_tgt;
    logic [COMPACT_OUT_W-1:0] cmp_word;

    assign req_item.func    = conv_req.func;
    assign req_item.compact = conv_req.compact_in;
    assign req_item.tgt     = {conv_req.tgt_in_3, conv_req.tgt_in_2,
                               conv_req.tgt_in_1, conv_req.tgt_in_0};

    // Output register frees up when empty or being drained
    assign out_adv  = !out_valid_reg || conv_rsp.ready;
    assign s1_ready = !s1_valid_reg || out_adv;
    assign req_take = s1_ready && conv_req.valid;

    assign conv_req.ready = s1_ready;

    assign s1_valid_next  = s1_ready ? conv_req.valid : s1_valid_reg;
    assign out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Conversion logic between the two registers
    cmpt_expand u_expand
    (
        .compact (s1_item_reg.compact),
        .tgt     (exp_tgt)
    );

    cmpt_compress u_compress
    (
        .tgt     (s1_item_reg.tgt),
        .compact (cmp_word)
    );

    // The unused half of the result reads as zero
    always_comb
    begin
        case (s1_item_reg.func)
            FUNC_EXPAND:
            begin
                out_item_next.tgt     = exp_tgt;
                out_item_next.compact = '0;
            end
            FUNC_COMPRESS:
            begin
                out_item_next.tgt     = '0;
                out_item_next.compact = cmp_word;
            end
            default:
            begin
                out_item_next.tgt     = '0;
                out_item_next.compact = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_item_reg <= req_item;
        end
        if (out_adv && s1_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign conv_rsp.valid       = out_valid_reg;
    assign conv_rsp.tgt_out_3   = out_item_reg.tgt[4*WORD_W-1 -: WORD_W];
    assign conv_rsp.tgt_out_2   = out_item_reg.tgt[3*WORD_W-1 -: WORD_W];
    assign conv_rsp.tgt_out_1   = out_item_reg.tgt[2*WORD_W-1 -: WORD_W];
    assign conv_rsp.tgt_out_0   = out_item_reg.tgt[WORD_W-1:0];
    assign conv_rsp.compact_out = out_item_reg.compact;

endmodule
